@@ rtl/core/tmcd_pkg.sv @@
// Shared types, widths and codes for the tolerant m/z cosine distance block.
// Used by every module under rtl/core; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package tmcd_pkg;

  localparam int MAX_PEAKS = 256;
  localparam int ADDR_W    = $clog2(MAX_PEAKS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int MZ_W      = 26;
  localparam int INT_W     = 16;
  localparam int SQ_W      = 2 * INT_W;
  localparam int MAG_W     = SQ_W + ADDR_W;
  localparam int MUL_A_W   = 2 * MAG_W;
  localparam int MUL_B_W   = MAG_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIST_W    = 17;
  localparam int ODD_W     = DIST_W + 1;
  localparam int BIT_W     = $clog2(DIST_W);
  localparam int SHIFT_D   = 2 * DIST_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CMD_W      = 2;

  localparam logic [DIST_W-1:0] ONE_Q16   = DIST_W'(65536);
  localparam logic [MZ_W-1:0]   TOL_RESET = MZ_W'(328);

  localparam logic [CMD_W-1:0] CMD_LOAD_L  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_R  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  typedef struct packed {
    logic [INT_W-1:0] intensity;
    logic [MZ_W-1:0]  mz;
  } peak_t;

endpackage
`default_nettype wire

@@ rtl/core/tmcd_peak_ram.sv @@
// Peak list memory: one write port for loads, one registered read port for the merge.
// Depends on tmcd_pkg for the peak type and address width.
`timescale 1ns / 1ps
`default_nettype none
module tmcd_peak_ram (
  input  wire                        clk,
  input  wire                        we,
  input  wire [tmcd_pkg::ADDR_W-1:0] waddr,
  input  wire tmcd_pkg::peak_t       wdata,
  input  wire [tmcd_pkg::ADDR_W-1:0] raddr,
  output tmcd_pkg::peak_t            rdata
);

  tmcd_pkg::peak_t mem [tmcd_pkg::MAX_PEAKS];
  tmcd_pkg::peak_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/tmcd_wide_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, for the final ratio test.
// Depends on tmcd_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none
module tmcd_wide_mul (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         go,
  input  wire [tmcd_pkg::MUL_A_W-1:0] a,
  input  wire [tmcd_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [tmcd_pkg::PROD_W-1:0] prod
);

  logic                        busy_r;
  logic                        done_r;
  logic [tmcd_pkg::PROD_W-1:0] a_r;
  logic [tmcd_pkg::MUL_B_W-1:0] b_r;
  logic [tmcd_pkg::PROD_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= tmcd_pkg::PROD_W'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

@@ rtl/core/tolerant_mz_cosine_distance.sv @@
// Usage notes for tolerant_mz_cosine_distance.
// Input words carry a command in in_tuser and a peak in in_tdata. Load-left and
// load-right words each append the peak to a 256-entry list; a load into a full
// list is dropped and marked. A compute word merges both lists with the m/z
// tolerance held in the cfg_ register (reset 328; the user must see that it is
// written only while the block is idle, which the block does not enforce), then
// emits one output word with the distance and the undefined and overflow flags,
// and empties both lists. A merge step is one registered list read, one compare
// and three passes through the shared 16x16 multiplier; there is one merge step
// per paired peak or per unpaired peak. The ratio test then runs on one
// shift-add multiplier at one bit per cycle: two setup products, then 17 result
// bits with two products each; a zero magnitude skips it.
// in_tready is low during the whole compute. The result waits in the output
// register while out_tready is low; loads are still accepted then, and a new
// compute holds its result back, with in_tready low, until the old one is taken.
// Reset empties both lists, clears the overflow mark and the output valid flag.
// Depends on tmcd_pkg, tmcd_peak_ram and tmcd_wide_mul.
`timescale 1ns / 1ps
`default_nettype none
module tolerant_mz_cosine_distance (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [tmcd_pkg::IN_DATA_W-1:0]    in_tdata,  // peak_mz[25:0], peak_intensity[41:26]
  input  wire [tmcd_pkg::CMD_W-1:0]        in_tuser,  // command[1:0]
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [tmcd_pkg::OUT_DATA_W-1:0]  out_tdata, // distance[16:0]
  output logic [1:0]                       out_tuser, // undefined_flag[0], overflow_flag[1]
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [tmcd_pkg::MZ_W-1:0]         cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_EV   = 11'b00000000100,
    S_SQL  = 11'b00000001000,
    S_SQR  = 11'b00000010000,
    S_DOT  = 11'b00000100000,
    S_PM   = 11'b00001000000,
    S_DM   = 11'b00010000000,
    S_QI   = 11'b00100000000,
    S_QM   = 11'b01000000000,
    S_TM   = 11'b10000000000
  } state_t;

  localparam logic [tmcd_pkg::CNT_W-1:0] FULL = tmcd_pkg::CNT_W'(tmcd_pkg::MAX_PEAKS);

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;
  logic [tmcd_pkg::CNT_W-1:0]  lc_r, lc_nxt, rc_r, rc_nxt, i_r, i_nxt, j_r, j_nxt;
  logic                        dropped_r, dropped_nxt;
  logic [tmcd_pkg::MZ_W-1:0]   tol_r;
  logic [tmcd_pkg::MAG_W-1:0]  mag_l_r, mag_l_nxt, mag_r_r, mag_r_nxt, dot_r, dot_nxt;
  logic [tmcd_pkg::INT_W-1:0]  li_r, li_nxt, ri_r, ri_nxt;
  logic                        do_l_r, do_l_nxt, do_r_r, do_r_nxt, do_d_r, do_d_nxt;
  logic [tmcd_pkg::MUL_A_W-1:0] p_r, p_nxt, d_r, d_nxt;
  logic [tmcd_pkg::DIST_W-1:0] s_r, s_nxt, dist_r, dist_nxt;
  logic [tmcd_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic                        undef_r, undef_nxt;
  logic                        out_valid_r;
  logic [tmcd_pkg::DIST_W-1:0] out_dist_r;
  logic                        out_undef_r, out_ovf_r;

  logic                        in_acc, we_l, we_r, lv, rv, pair, l_lt_r, ratio_ok, out_load;
  tmcd_pkg::peak_t             in_peak, lpk, rpk;
  logic [tmcd_pkg::MZ_W-1:0]   diff;
  logic [tmcd_pkg::INT_W-1:0]  sq_a, sq_b;
  logic [tmcd_pkg::SQ_W-1:0]   sq;
  logic [tmcd_pkg::DIST_W-1:0] cand;
  logic [tmcd_pkg::ODD_W-1:0]  odd;
  logic                        mul_go, mul_done;
  logic [tmcd_pkg::MUL_A_W-1:0] mul_a;
  logic [tmcd_pkg::MUL_B_W-1:0] mul_b;
  logic [tmcd_pkg::PROD_W-1:0] mul_p;

  assign in_tready = (state_r == S_IDLE) && !fin_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign in_peak   = tmcd_pkg::peak_t'(in_tdata[tmcd_pkg::MZ_W+tmcd_pkg::INT_W-1:0]);
  assign we_l      = in_acc && (in_tuser == tmcd_pkg::CMD_LOAD_L) && (lc_r != FULL);
  assign we_r      = in_acc && (in_tuser == tmcd_pkg::CMD_LOAD_R) && (rc_r != FULL);

  tmcd_peak_ram u_left (
    .clk(clk), .we(we_l), .waddr(lc_r[tmcd_pkg::ADDR_W-1:0]), .wdata(in_peak),
    .raddr(i_r[tmcd_pkg::ADDR_W-1:0]), .rdata(lpk)
  );

  tmcd_peak_ram u_right (
    .clk(clk), .we(we_r), .waddr(rc_r[tmcd_pkg::ADDR_W-1:0]), .wdata(in_peak),
    .raddr(j_r[tmcd_pkg::ADDR_W-1:0]), .rdata(rpk)
  );

  tmcd_wide_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  // Merge decision on the peaks read at i and j.
  assign lv     = i_r < lc_r;
  assign rv     = j_r < rc_r;
  assign l_lt_r = lpk.mz < rpk.mz;
  assign diff   = l_lt_r ? (rpk.mz - lpk.mz) : (lpk.mz - rpk.mz);
  assign pair   = lv && rv && (diff <= tol_r);

  // Shared 16x16 multiplier for the squares and the pair product.
  always_comb begin
    case (state_r)
      S_SQR:   begin sq_a = ri_r; sq_b = ri_r; end
      S_DOT:   begin sq_a = li_r; sq_b = ri_r; end
      default: begin sq_a = li_r; sq_b = li_r; end
    endcase
  end
  assign sq = sq_a * sq_b;

  // Result bit search: cand rounds into range when (2c-1)^2*magL*magR <= (dot<<17)^2.
  assign cand     = s_r | (tmcd_pkg::DIST_W'(1) << bit_r);
  assign odd      = {cand, 1'b0} - tmcd_pkg::ODD_W'(1);
  assign ratio_ok = mul_p <= tmcd_pkg::PROD_W'({d_r, {tmcd_pkg::SHIFT_D{1'b0}}});
  assign out_load = fin_r && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    fin_nxt     = fin_r;
    lc_nxt      = lc_r;
    rc_nxt      = rc_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    dropped_nxt = dropped_r;
    mag_l_nxt   = mag_l_r;
    mag_r_nxt   = mag_r_r;
    dot_nxt     = dot_r;
    li_nxt      = li_r;
    ri_nxt      = ri_r;
    do_l_nxt    = do_l_r;
    do_r_nxt    = do_r_r;
    do_d_nxt    = do_d_r;
    p_nxt       = p_r;
    d_nxt       = d_r;
    s_nxt       = s_r;
    bit_nxt     = bit_r;
    dist_nxt    = dist_r;
    undef_nxt   = undef_r;
    mul_go      = 1'b0;
    mul_a       = tmcd_pkg::MUL_A_W'(odd);
    mul_b       = tmcd_pkg::MUL_B_W'(odd);
    case (state_r)
      S_IDLE: begin
        if (out_load) begin
          fin_nxt     = 1'b0;
          lc_nxt      = '0;
          rc_nxt      = '0;
          dropped_nxt = 1'b0;
        end else if (in_acc) begin
          case (in_tuser)
            tmcd_pkg::CMD_LOAD_L: begin
              if (lc_r == FULL) dropped_nxt = 1'b1;
              else lc_nxt = lc_r + 1'b1;
            end
            tmcd_pkg::CMD_LOAD_R: begin
              if (rc_r == FULL) dropped_nxt = 1'b1;
              else rc_nxt = rc_r + 1'b1;
            end
            tmcd_pkg::CMD_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              mag_l_nxt = '0;
              mag_r_nxt = '0;
              dot_nxt   = '0;
              state_nxt = S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (lv || rv) begin
          state_nxt = S_EV;
        end else if ((mag_l_r == '0) || (mag_r_r == '0)) begin
          undef_nxt = 1'b1;
          dist_nxt  = tmcd_pkg::ONE_Q16;
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          undef_nxt = 1'b0;
          mul_go    = 1'b1;
          mul_a     = tmcd_pkg::MUL_A_W'(mag_l_r);
          mul_b     = mag_r_r;
          state_nxt = S_PM;
        end
      end
      S_EV: begin
        li_nxt    = lpk.intensity;
        ri_nxt    = rpk.intensity;
        do_d_nxt  = pair;
        do_l_nxt  = lv && (!rv || pair || l_lt_r);
        do_r_nxt  = rv && (!lv || pair || !l_lt_r);
        state_nxt = S_SQL;
      end
      S_SQL: begin
        if (do_l_r) mag_l_nxt = mag_l_r + tmcd_pkg::MAG_W'(sq);
        state_nxt = S_SQR;
      end
      S_SQR: begin
        if (do_r_r) mag_r_nxt = mag_r_r + tmcd_pkg::MAG_W'(sq);
        state_nxt = S_DOT;
      end
      S_DOT: begin
        if (do_d_r) dot_nxt = dot_r + tmcd_pkg::MAG_W'(sq);
        i_nxt     = i_r + tmcd_pkg::CNT_W'(do_l_r);
        j_nxt     = j_r + tmcd_pkg::CNT_W'(do_r_r);
        state_nxt = S_RD;
      end
      S_PM: begin
        if (mul_done) begin
          p_nxt     = mul_p[tmcd_pkg::MUL_A_W-1:0];
          mul_go    = 1'b1;
          mul_a     = tmcd_pkg::MUL_A_W'(dot_r);
          mul_b     = dot_r;
          state_nxt = S_DM;
        end
      end
      S_DM: begin
        if (mul_done) begin
          d_nxt     = mul_p[tmcd_pkg::MUL_A_W-1:0];
          s_nxt     = '0;
          bit_nxt   = tmcd_pkg::BIT_W'(tmcd_pkg::DIST_W - 1);
          state_nxt = S_QI;
        end
      end
      S_QI: begin
        mul_go    = 1'b1;
        state_nxt = S_QM;
      end
      S_QM: begin
        if (mul_done) begin
          mul_go    = 1'b1;
          mul_a     = p_r;
          mul_b     = mul_p[tmcd_pkg::MUL_B_W-1:0];
          state_nxt = S_TM;
        end
      end
      S_TM: begin
        if (mul_done) begin
          if (ratio_ok) s_nxt = cand;
          if (bit_r == '0) begin
            dist_nxt  = tmcd_pkg::ONE_Q16 - (ratio_ok ? cand : s_r);
            fin_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            state_nxt = S_QI;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      lc_r        <= '0;
      rc_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      dropped_r   <= 1'b0;
      tol_r       <= tmcd_pkg::TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fin_r     <= fin_nxt;
      lc_r      <= lc_nxt;
      rc_r      <= rc_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_valid && cfg_ready) tol_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mag_l_r <= mag_l_nxt;
    mag_r_r <= mag_r_nxt;
    dot_r   <= dot_nxt;
    li_r    <= li_nxt;
    ri_r    <= ri_nxt;
    do_l_r  <= do_l_nxt;
    do_r_r  <= do_r_nxt;
    do_d_r  <= do_d_nxt;
    p_r     <= p_nxt;
    d_r     <= d_nxt;
    s_r     <= s_nxt;
    bit_r   <= bit_nxt;
    dist_r  <= dist_nxt;
    undef_r <= undef_nxt;
    if (out_load) begin
      out_dist_r  <= dist_r;
      out_undef_r <= undef_r;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tmcd_pkg::OUT_DATA_W'(out_dist_r);
  assign out_tuser  = {out_ovf_r, out_undef_r};

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lc_r <= FULL) && (rc_r <= FULL))
    else $error("peak count beyond list capacity");
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((i_r <= lc_r) && (j_r <= rc_r)))
    else $error("merge pointer ran past its list");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_dist_r <= tmcd_pkg::ONE_Q16))
    else $error("distance above one");
`endif

endmodule
`default_nettype wire
